@@ src/qhog_pkg.sv @@
// ----------------------------------------------------------------------------
// qhog_pkg: shared types and constants for the quantile hysteresis onset gate
// Widths of the sample, marker and arithmetic paths, sequencer states and
// the request/response bundle of the shared multiply/divide unit.
// ----------------------------------------------------------------------------
package qhog_pkg;

  // sample and marker height width, signed
  localparam int SW   = 32;
  // marker position width
  localparam int CW   = 32;
  // quantile fraction bits
  localparam int QW   = 16;
  // desired position width: integer part over quantile fraction
  localparam int DW   = CW + QW;
  // number of markers per estimator
  localparam int NM   = 5;
  // operand width of the multiply/divide unit (products, numerators)
  localparam int PW   = 66;
  // divisor and multiplier width
  localparam int DVW  = 33;
  // step counter width of the multiply/divide unit
  localparam int CNTW = $clog2(PW + 1);
  // one in quantile fixed point
  localparam int QONE = 1 << QW;

  // configuration register indexes
  localparam logic [1:0] CFG_HIGH_Q = 2'd0;
  localparam logic [1:0] CFG_LOW_Q  = 2'd1;
  localparam logic [1:0] CFG_REFR   = 2'd2;
  localparam logic [1:0] CFG_WARM   = 2'd3;

  typedef enum logic {
    MDU_MUL,
    MDU_DIV
  } qhog_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SORT,
    ST_SEED,
    ST_BOUND,
    ST_MARK,
    ST_MUL1,
    ST_DIV1,
    ST_MUL2,
    ST_DIV2,
    ST_DIV3,
    ST_CHK,
    ST_LIN,
    ST_ROT,
    ST_FIN,
    ST_GATE
  } qhog_state_t;

  typedef struct packed {
    logic            start;
    qhog_op_t        op;
    logic [PW-1:0]   opa;
    logic [DVW-1:0]  opb;
  } qhog_mdu_req_t;

  typedef struct packed {
    logic          done;
    logic [PW-1:0] result;
  } qhog_mdu_rsp_t;

endpackage

@@ src/qhog_mdu.sv @@
// ----------------------------------------------------------------------------
// qhog_mdu: shared bit-serial multiply/divide unit
// Shift-add multiply (one multiplier bit per cycle) and restoring unsigned
// division (one quotient bit per cycle). Division by zero returns zero.
// ----------------------------------------------------------------------------
module qhog_mdu
  import qhog_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  qhog_mdu_req_t req,
  output qhog_mdu_rsp_t rsp
);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  qhog_op_t        op_r, op_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0]   acc_r, acc_nxt;
  logic [PW-1:0]   sh_r, sh_nxt;
  logic [DVW-1:0]  mp_r, mp_nxt;
  logic [DVW-1:0]  rem_r, rem_nxt;
  logic [DVW:0]    trial;
  logic            ge;

  // restoring division trial subtract
  assign trial = {rem_r, sh_r[PW-1]};
  assign ge    = (trial >= {1'b0, mp_r});

  // sequencing of one operation
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    sh_nxt   = sh_r;
    mp_nxt   = mp_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      op_nxt  = req.op;
      acc_nxt = '0;
      sh_nxt  = req.opa;
      mp_nxt  = req.opb;
      rem_nxt = '0;
      if (req.op == MDU_DIV) begin
        cnt_nxt = CNTW'(PW);
        if (req.opb == '0) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end else begin
          busy_nxt = 1'b1;
        end
      end else begin
        cnt_nxt  = CNTW'(DVW);
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      unique case (op_r)
        MDU_MUL: begin
          if (mp_r[0]) acc_nxt = acc_r + sh_r;
          sh_nxt = {sh_r[PW-2:0], 1'b0};
          mp_nxt = {1'b0, mp_r[DVW-1:1]};
        end
        MDU_DIV: begin
          if (ge) rem_nxt = DVW'(trial - {1'b0, mp_r});
          else    rem_nxt = trial[DVW-1:0];
          acc_nxt = {acc_r[PW-2:0], ge};
          sh_nxt  = {sh_r[PW-2:0], 1'b0};
        end
        default: ;
      endcase
      cnt_nxt = cnt_r - CNTW'(1);
      if (cnt_r == CNTW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    sh_r  <= sh_nxt;
    mp_r  <= mp_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done   = done_r;
  assign rsp.result = acc_r;

endmodule

@@ src/quantile_hysteresis_onset_gate.sv @@
// ----------------------------------------------------------------------------
// quantile_hysteresis_onset_gate: onset gate over two running quantiles
// Two P-square estimators track a high and a low quantile of the novelty
// samples; an armed gate fires when a sample drops below the low estimate.
// ----------------------------------------------------------------------------
// Usage
//   in_*  : one signed 16.16 novelty sample per item, one item per frame.
//   out_* : one item per input item, tdata[0] is the hit flag.
//   cfg_* : register writes (0 high q, 1 low q, 2 refractory, 3 warmup),
//           always ready, to be written while the block is idle.
// Item processing
//   One item is worked on at a time; in_tready is low meanwhile. The first
//   four items only store a seed sample; the fifth also sorts the seeds in
//   five passes and seeds both estimators. Later items walk each estimator's
//   three inner markers through the one shared multiply/divide unit: a
//   marker that moves costs two multiplies and three or four divides.
// Reset
//   Synchronous active-low reset clears the gate, counters and the seeding
//   state and loads the register defaults; marker stores are seeded later.
// Back-pressure
//   The result sits in an output register; the next item is accepted while
//   it waits, and its result is held back until the receiver takes the first.
// ----------------------------------------------------------------------------
module quantile_hysteresis_onset_gate
  import qhog_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // [31:0] sample
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [0] hit, [7:1] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_data
);

  localparam logic signed [DW:0] DQ_ONE = (DW+1)'(QONE);

  qhog_state_t state_r, state_nxt;

  logic [QW-1:0] hq_r, hq_nxt, lq_r, lq_nxt;
  logic [15:0]   refr_r, refr_nxt, warm_r, warm_nxt;
  logic          armed_r, armed_nxt;
  logic [15:0]   refl_r, refl_nxt;
  logic [CW-1:0] seen_r, seen_nxt;
  logic          ready_r, ready_nxt;
  logic          est_sel_r, est_sel_nxt;
  logic          op_busy_r, op_busy_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_hit_r, out_hit_nxt;

  logic signed [SW-1:0] x_r, x_nxt;
  logic signed [SW-1:0] seed_r [NM];
  logic signed [SW-1:0] seed_nxt [NM];
  logic signed [SW-1:0] wh_r [NM];
  logic signed [SW-1:0] wh_nxt [NM];
  logic [CW-1:0]        wn_r [NM];
  logic [CW-1:0]        wn_nxt [NM];
  logic [DW-1:0]        wp_r [NM];
  logic [DW-1:0]        wp_nxt [NM];
  logic signed [SW-1:0] oh_r [NM];
  logic signed [SW-1:0] oh_nxt [NM];
  logic [CW-1:0]        on_r [NM];
  logic [CW-1:0]        on_nxt [NM];
  logic [DW-1:0]        op_r [NM];
  logic [DW-1:0]        op_nxt [NM];

  logic [2:0]    pass_r, pass_nxt;
  logic [2:0]    rot_r, rot_nxt;
  logic          up_r, up_nxt;
  logic [CW-1:0] a_r, a_nxt, b_r, b_nxt;
  logic [SW-1:0] dq1_r, dq1_nxt, dq0_r, dq0_nxt;
  logic [PW-1:0] t1_r, t1_nxt, adj_r, adj_nxt;

  qhog_mdu_req_t mdu_req;
  qhog_mdu_rsp_t mdu_rsp;

  // marker window helpers, inner marker at slot 1
  logic [QW-1:0]        q_cur;
  logic [QW:0]          half_sum;
  logic [NM-1:0]        ltv;
  logic signed [DW:0]   diff;
  logic                 up_c, dn_c, cond_c;
  logic [CW-1:0]        a_c, b_c;
  logic [SW-1:0]        dq1_c, dq0_c;
  logic                 adj_small, adj_zero, ok_c;
  logic [CW-1:0]        seen_inc;
  logic [15:0]          refl_dec;
  logic                 gate_on, arm_c, out_free;
  logic [2:0]           seed_idx;

  assign q_cur    = est_sel_r ? lq_r : hq_r;
  assign half_sum = {1'b0, q_cur} + (QW+1)'(QONE);
  assign diff     = $signed({1'b0, wp_r[1]}) - $signed({1'b0, wn_r[1], {QW{1'b0}}});
  assign up_c     = (diff >= DQ_ONE);
  assign dn_c     = (diff <= -DQ_ONE);
  assign a_c      = wn_r[1] - wn_r[0];
  assign b_c      = wn_r[2] - wn_r[1];
  assign dq1_c    = SW'(wh_r[2] - wh_r[1]);
  assign dq0_c    = SW'(wh_r[1] - wh_r[0]);
  assign cond_c   = (up_c && (b_c > CW'(1))) || (dn_c && (a_c > CW'(1)));

  // parabolic candidate must stay strictly between the neighbours
  assign adj_zero  = (adj_r == '0);
  assign adj_small = (adj_r[PW-1:SW] == '0) &&
                     (adj_r[SW-1:0] < (up_r ? dq1_r : dq0_r));
  assign ok_c      = adj_small && !(adj_zero && ((up_r ? dq0_r : dq1_r) == '0));

  assign seen_inc = (seen_r == '1) ? seen_r : seen_r + CW'(1);
  assign refl_dec = (refl_r != '0) ? refl_r - 16'd1 : refl_r;
  assign gate_on  = (seen_inc > CW'(warm_r)) && ready_r;
  assign arm_c    = armed_r || ((refl_dec == '0) && (x_r > wh_r[2]));
  assign out_free = !out_valid_r || out_tready;
  assign seed_idx = (seen_r < CW'(4)) ? seen_r[2:0] : 3'd4;

  always_comb begin
    for (int i = 0; i < NM; i++) ltv[i] = (x_r < wh_r[i]);
  end

  // sequencer: next state, datapath updates and unit requests
  always_comb begin
    state_nxt     = state_r;
    hq_nxt        = hq_r;
    lq_nxt        = lq_r;
    refr_nxt      = refr_r;
    warm_nxt      = warm_r;
    armed_nxt     = armed_r;
    refl_nxt      = refl_r;
    seen_nxt      = seen_r;
    ready_nxt     = ready_r;
    est_sel_nxt   = est_sel_r;
    op_busy_nxt   = op_busy_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_hit_nxt   = out_hit_r;
    x_nxt         = x_r;
    pass_nxt      = pass_r;
    rot_nxt       = rot_r;
    up_nxt        = up_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    dq1_nxt       = dq1_r;
    dq0_nxt       = dq0_r;
    t1_nxt        = t1_r;
    adj_nxt       = adj_r;
    for (int i = 0; i < NM; i++) begin
      seed_nxt[i] = seed_r[i];
      wh_nxt[i]   = wh_r[i];
      wn_nxt[i]   = wn_r[i];
      wp_nxt[i]   = wp_r[i];
      oh_nxt[i]   = oh_r[i];
      on_nxt[i]   = on_r[i];
      op_nxt[i]   = op_r[i];
    end
    mdu_req.start = 1'b0;
    mdu_req.op    = MDU_MUL;
    mdu_req.opa   = '0;
    mdu_req.opb   = '0;

    // register writes
    if (cfg_valid) begin
      unique case (cfg_addr)
        CFG_HIGH_Q: hq_nxt   = cfg_data;
        CFG_LOW_Q:  lq_nxt   = cfg_data;
        CFG_REFR:   refr_nxt = cfg_data;
        CFG_WARM:   warm_nxt = cfg_data;
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          x_nxt = in_tdata;
          if (!ready_r) begin
            seed_nxt[seed_idx] = in_tdata;
            if (seed_idx == 3'd4) begin
              pass_nxt  = '0;
              state_nxt = ST_SORT;
            end else begin
              state_nxt = ST_GATE;
            end
          end else begin
            state_nxt = ST_BOUND;
          end
        end
      end

      // odd-even transposition pass over the seed samples
      ST_SORT: begin
        if (!pass_r[0]) begin
          if (seed_r[0] > seed_r[1]) begin
            seed_nxt[0] = seed_r[1];
            seed_nxt[1] = seed_r[0];
          end
          if (seed_r[2] > seed_r[3]) begin
            seed_nxt[2] = seed_r[3];
            seed_nxt[3] = seed_r[2];
          end
        end else begin
          if (seed_r[1] > seed_r[2]) begin
            seed_nxt[1] = seed_r[2];
            seed_nxt[2] = seed_r[1];
          end
          if (seed_r[3] > seed_r[4]) begin
            seed_nxt[3] = seed_r[4];
            seed_nxt[4] = seed_r[3];
          end
        end
        pass_nxt = pass_r + 3'd1;
        if (pass_r == 3'(NM - 1)) state_nxt = ST_SEED;
      end

      // seed both estimators from the sorted samples
      ST_SEED: begin
        for (int i = 0; i < NM; i++) begin
          wh_nxt[i] = seed_r[i];
          oh_nxt[i] = seed_r[i];
          wn_nxt[i] = CW'(i + 1);
          on_nxt[i] = CW'(i + 1);
        end
        wp_nxt[0] = DW'(QONE);
        wp_nxt[1] = DW'(QONE) + DW'({hq_r, 1'b0});
        wp_nxt[2] = DW'(QONE) + DW'({hq_r, 2'b0});
        wp_nxt[3] = DW'(3 * QONE) + DW'({hq_r, 1'b0});
        wp_nxt[4] = DW'(5 * QONE);
        op_nxt[0] = DW'(QONE);
        op_nxt[1] = DW'(QONE) + DW'({lq_r, 1'b0});
        op_nxt[2] = DW'(QONE) + DW'({lq_r, 2'b0});
        op_nxt[3] = DW'(3 * QONE) + DW'({lq_r, 1'b0});
        op_nxt[4] = DW'(5 * QONE);
        ready_nxt = 1'b1;
        state_nxt = ST_GATE;
      end

      // extremes, marker positions and desired positions
      ST_BOUND: begin
        rot_nxt = '0;
        if (wn_r[NM-1] == '1) begin
          state_nxt = ST_FIN;
        end else begin
          if (ltv[0]) begin
            wh_nxt[0] = x_r;
            for (int i = 1; i < NM; i++) wn_nxt[i] = wn_r[i] + CW'(1);
          end else if (!ltv[NM-1]) begin
            wh_nxt[NM-1] = x_r;
            wn_nxt[NM-1] = wn_r[NM-1] + CW'(1);
          end else begin
            wn_nxt[1]    = wn_r[1] + CW'(ltv[1]);
            wn_nxt[2]    = wn_r[2] + CW'(ltv[1] || ltv[2]);
            wn_nxt[3]    = wn_r[3] + CW'(ltv[1] || ltv[2] || ltv[3]);
            wn_nxt[NM-1] = wn_r[NM-1] + CW'(1);
          end
          wp_nxt[1] = wp_r[1] + DW'(q_cur[QW-1:1]);
          wp_nxt[2] = wp_r[2] + DW'(q_cur);
          wp_nxt[3] = wp_r[3] + DW'(half_sum[QW:1]);
          wp_nxt[4] = wp_r[4] + DW'(QONE);
          state_nxt = ST_MARK;
        end
      end

      // decide whether the inner marker moves
      ST_MARK: begin
        up_nxt  = up_c;
        a_nxt   = a_c;
        b_nxt   = b_c;
        dq1_nxt = dq1_c;
        dq0_nxt = dq0_c;
        state_nxt = cond_c ? ST_MUL1 : ST_ROT;
      end

      ST_MUL1: begin
        mdu_req.start = !op_busy_r;
        mdu_req.op    = MDU_MUL;
        mdu_req.opa   = up_r ? PW'({1'b0, a_r} + DVW'(1)) : PW'({1'b0, a_r} - DVW'(1));
        mdu_req.opb   = DVW'(dq1_r);
        if (mdu_rsp.done && op_busy_r) begin
          t1_nxt    = mdu_rsp.result;
          state_nxt = ST_DIV1;
        end
      end

      ST_DIV1: begin
        mdu_req.start = !op_busy_r;
        mdu_req.op    = MDU_DIV;
        mdu_req.opa   = t1_r;
        mdu_req.opb   = DVW'(b_r);
        if (mdu_rsp.done && op_busy_r) begin
          t1_nxt    = mdu_rsp.result;
          state_nxt = ST_MUL2;
        end
      end

      ST_MUL2: begin
        mdu_req.start = !op_busy_r;
        mdu_req.op    = MDU_MUL;
        mdu_req.opa   = up_r ? PW'({1'b0, b_r} - DVW'(1)) : PW'({1'b0, b_r} + DVW'(1));
        mdu_req.opb   = DVW'(dq0_r);
        if (mdu_rsp.done && op_busy_r) begin
          adj_nxt   = mdu_rsp.result;
          state_nxt = ST_DIV2;
        end
      end

      ST_DIV2: begin
        mdu_req.start = !op_busy_r;
        mdu_req.op    = MDU_DIV;
        mdu_req.opa   = adj_r;
        mdu_req.opb   = DVW'(a_r);
        if (mdu_rsp.done && op_busy_r) begin
          adj_nxt   = t1_r + mdu_rsp.result;
          state_nxt = ST_DIV3;
        end
      end

      ST_DIV3: begin
        mdu_req.start = !op_busy_r;
        mdu_req.op    = MDU_DIV;
        mdu_req.opa   = adj_r;
        mdu_req.opb   = {1'b0, a_r} + {1'b0, b_r};
        if (mdu_rsp.done && op_busy_r) begin
          adj_nxt   = mdu_rsp.result;
          state_nxt = ST_CHK;
        end
      end

      // take the parabolic step or fall back to the linear one
      ST_CHK: begin
        if (ok_c) begin
          wh_nxt[1] = up_r ? wh_r[1] + $signed(adj_r[SW-1:0])
                           : wh_r[1] - $signed(adj_r[SW-1:0]);
          wn_nxt[1] = up_r ? wn_r[1] + CW'(1) : wn_r[1] - CW'(1);
          state_nxt = ST_ROT;
        end else begin
          state_nxt = ST_LIN;
        end
      end

      ST_LIN: begin
        mdu_req.start = !op_busy_r;
        mdu_req.op    = MDU_DIV;
        mdu_req.opa   = PW'(up_r ? dq1_r : dq0_r);
        mdu_req.opb   = DVW'(up_r ? b_r : a_r);
        if (mdu_rsp.done && op_busy_r) begin
          wh_nxt[1] = up_r ? wh_r[1] + $signed(mdu_rsp.result[SW-1:0])
                           : wh_r[1] - $signed(mdu_rsp.result[SW-1:0]);
          wn_nxt[1] = up_r ? wn_r[1] + CW'(1) : wn_r[1] - CW'(1);
          state_nxt = ST_ROT;
        end
      end

      // rotate the marker window by one slot
      ST_ROT: begin
        for (int i = 0; i < NM - 1; i++) begin
          wh_nxt[i] = wh_r[i+1];
          wn_nxt[i] = wn_r[i+1];
          wp_nxt[i] = wp_r[i+1];
        end
        wh_nxt[NM-1] = wh_r[0];
        wn_nxt[NM-1] = wn_r[0];
        wp_nxt[NM-1] = wp_r[0];
        rot_nxt = rot_r + 3'd1;
        if (rot_r == 3'(NM - 1))  state_nxt = ST_FIN;
        else if (rot_r < 3'd2)    state_nxt = ST_MARK;
        else                      state_nxt = ST_ROT;
      end

      // exchange the banks, low estimator next or done
      ST_FIN: begin
        for (int i = 0; i < NM; i++) begin
          wh_nxt[i] = oh_r[i];
          wn_nxt[i] = on_r[i];
          wp_nxt[i] = op_r[i];
          oh_nxt[i] = wh_r[i];
          on_nxt[i] = wn_r[i];
          op_nxt[i] = wp_r[i];
        end
        est_sel_nxt = !est_sel_r;
        state_nxt   = est_sel_r ? ST_GATE : ST_BOUND;
      end

      // counters, hysteresis gate and result
      ST_GATE: begin
        if (out_free) begin
          seen_nxt      = seen_inc;
          refl_nxt      = refl_dec;
          out_valid_nxt = 1'b1;
          out_hit_nxt   = 1'b0;
          if (gate_on) begin
            armed_nxt = arm_c;
            if (arm_c && (x_r < oh_r[2])) begin
              out_hit_nxt = 1'b1;
              armed_nxt   = 1'b0;
              refl_nxt    = refr_r;
            end
          end
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    if (mdu_req.start)     op_busy_nxt = 1'b1;
    else if (mdu_rsp.done) op_busy_nxt = 1'b0;
  end

  qhog_mdu u_mdu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mdu_req),
    .rsp   (mdu_rsp)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      hq_r        <= 16'd58982;
      lq_r        <= 16'd32768;
      refr_r      <= 16'd4;
      warm_r      <= 16'd5;
      armed_r     <= 1'b0;
      refl_r      <= '0;
      seen_r      <= '0;
      ready_r     <= 1'b0;
      est_sel_r   <= 1'b0;
      op_busy_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hq_r        <= hq_nxt;
      lq_r        <= lq_nxt;
      refr_r      <= refr_nxt;
      warm_r      <= warm_nxt;
      armed_r     <= armed_nxt;
      refl_r      <= refl_nxt;
      seen_r      <= seen_nxt;
      ready_r     <= ready_nxt;
      est_sel_r   <= est_sel_nxt;
      op_busy_r   <= op_busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and marker stores
  always_ff @(posedge clk) begin
    out_hit_r <= out_hit_nxt;
    x_r       <= x_nxt;
    pass_r    <= pass_nxt;
    rot_r     <= rot_nxt;
    up_r      <= up_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    dq1_r     <= dq1_nxt;
    dq0_r     <= dq0_nxt;
    t1_r      <= t1_nxt;
    adj_r     <= adj_nxt;
    for (int i = 0; i < NM; i++) begin
      seed_r[i] <= seed_nxt[i];
      wh_r[i]   <= wh_nxt[i];
      wn_r[i]   <= wn_nxt[i];
      wp_r[i]   <= wp_nxt[i];
      oh_r[i]   <= oh_nxt[i];
      on_r[i]   <= on_nxt[i];
      op_r[i]   <= op_nxt[i];
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_hit_r};
  assign cfg_ready  = 1'b1;

`ifndef SYNTHESIS
  // the high estimator sits in the working bank between items
  a_bank_home: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !est_sel_r)
    else $error("estimator banks not restored at idle");

  // once seeded the estimators stay seeded
  a_ready_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ready_r |=> ready_r)
    else $error("seeded flag dropped");

  // each unit request is followed by a pending operation
  a_issue_once: assert property (@(posedge clk) disable iff (!rst_n)
    mdu_req.start |=> op_busy_r)
    else $error("unit request not tracked");

  // an accepted item always starts work
  a_accept_work: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r != ST_IDLE))
    else $error("accepted item left idle");

  // a new result only comes out of the gate step
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == ST_GATE))
    else $error("result raised outside gate step");
`endif

endmodule

@@ tb/tb_quantile_hysteresis_onset_gate.sv @@
// ----------------------------------------------------------------------------
// tb_quantile_hysteresis_onset_gate: self-checking bench for the onset gate
// Streams novelty samples through the gate under several register settings
// and flow-control patterns. A behavioural copy of the two running quantile
// estimators and the hysteresis gate predicts each hit flag, and every
// result item is compared with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_quantile_hysteresis_onset_gate;
  import qhog_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;    // [31:0] sample
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;        // [0] hit, [7:1] zero
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_addr = '0;
  logic [15:0] cfg_data = '0;

  quantile_hysteresis_onset_gate DUT (.*);

  localparam longint unsigned CNT_MAX = 64'hFFFF_FFFF;
  localparam longint unsigned Q_ONE   = 64'd65536;

  // flow control of the current phase
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // expected hit flags, oldest first
  bit hit_queue[$];
  int errors = 0;
  int items_sent = 0;
  int hits_seen = 0;

  // gate model: registers and state
  longint unsigned q_high, q_low, refr_frames, warm_frames;
  bit              gate_armed, est_ready;
  longint unsigned refr_left, seen_cnt;
  longint          seed_buf[NM];
  longint          hgt[2][NM];
  longint unsigned pos[2][NM];
  longint unsigned des[2][NM];

  // clock
  initial begin
    forever #4 clk = ~clk;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (hit_queue.size() == 0) begin
        $error("unexpected result item hit=%0d", out_tdata[0]);
        errors++;
      end else begin
        bit exp_hit;
        exp_hit = hit_queue.pop_front();
        if (out_tdata[0] !== exp_hit) begin
          $error("hit mismatch: expected %0d actual %0d", exp_hit, out_tdata[0]);
          errors++;
        end
        if (out_tdata[0] === 1'b1) hits_seen++;
      end
    end
  end

  // seed one estimator from the five sorted first samples
  task automatic seed_estimator(int e, longint unsigned q);
    longint s[NM];
    longint v;
    int j;
    s = seed_buf;
    for (int i = 1; i < NM; i++) begin
      v = s[i];
      j = i;
      while (j > 0 && s[j-1] > v) begin
        s[j] = s[j-1];
        j--;
      end
      s[j] = v;
    end
    for (int i = 0; i < NM; i++) begin
      hgt[e][i] = s[i];
      pos[e][i] = i + 1;
    end
    des[e][0] = Q_ONE;
    des[e][1] = Q_ONE + 2 * q;
    des[e][2] = Q_ONE + 4 * q;
    des[e][3] = 3 * Q_ONE + 2 * q;
    des[e][4] = 5 * Q_ONE;
  endtask

  // one P-square marker update for estimator e
  task automatic update_estimator(int e, longint unsigned q, longint x);
    longint unsigned inc[NM];
    longint unsigned a, b, dq0, dq1, m1, m2;
    longint diff;
    bit [127:0] t1, t2, adj;
    bit up, ok;
    int k;
    if (pos[e][4] >= CNT_MAX) return;
    if (x < hgt[e][0]) begin
      hgt[e][0] = x;
      k = 0;
    end else if (x >= hgt[e][4]) begin
      hgt[e][4] = x;
      k = 3;
    end else begin
      k = 0;
      while (k < 3 && !(x < hgt[e][k+1])) k++;
    end
    for (int i = k + 1; i < NM; i++) pos[e][i]++;
    inc[0] = 0;
    inc[1] = q >> 1;
    inc[2] = q;
    inc[3] = (Q_ONE + q) >> 1;
    inc[4] = Q_ONE;
    for (int i = 0; i < NM; i++) des[e][i] += inc[i];
    for (int i = 1; i <= 3; i++) begin
      diff = longint'(des[e][i]) - longint'(pos[e][i] << 16);
      a = pos[e][i] - pos[e][i-1];
      b = pos[e][i+1] - pos[e][i];
      up = (diff >= longint'(Q_ONE));
      if ((up && b > 1) || (diff <= -longint'(Q_ONE) && a > 1)) begin
        dq1 = hgt[e][i+1] - hgt[e][i];
        dq0 = hgt[e][i] - hgt[e][i-1];
        m1 = up ? a + 1 : a - 1;
        m2 = up ? b - 1 : b + 1;
        t1 = (128'(m1) * 128'(dq1)) / 128'(b);
        t2 = (128'(m2) * 128'(dq0)) / 128'(a);
        adj = (t1 + t2) / 128'(a + b);
        ok = up ? (adj < 128'(dq1) && !(adj == 0 && dq0 == 0))
                : (adj < 128'(dq0) && !(adj == 0 && dq1 == 0));
        if (ok) hgt[e][i] = up ? hgt[e][i] + longint'(adj[63:0])
                               : hgt[e][i] - longint'(adj[63:0]);
        else hgt[e][i] = up ? hgt[e][i] + longint'(dq1 / b)
                            : hgt[e][i] - longint'(dq0 / a);
        if (up) pos[e][i]++;
        else pos[e][i]--;
      end
    end
  endtask

  // advance the gate model by one sample and return the hit flag
  task automatic gate_step(logic [31:0] raw, output bit hit);
    longint x;
    longint unsigned idx;
    x = longint'(signed'(raw));
    hit = 1'b0;
    if (!est_ready) begin
      idx = (seen_cnt < 4) ? seen_cnt : 4;
      seed_buf[idx] = x;
      if (idx == 4) begin
        seed_estimator(0, q_high);
        seed_estimator(1, q_low);
        est_ready = 1'b1;
      end
    end else begin
      update_estimator(0, q_high, x);
      update_estimator(1, q_low, x);
    end
    if (seen_cnt < CNT_MAX) seen_cnt++;
    if (refr_left > 0) refr_left--;
    if (seen_cnt > warm_frames && est_ready) begin
      if (!gate_armed && refr_left == 0 && x > hgt[0][2]) gate_armed = 1'b1;
      if (gate_armed && x < hgt[1][2]) begin
        hit = 1'b1;
        gate_armed = 1'b0;
        refr_left = refr_frames;
      end
    end
  endtask

  // send one sample item; entered and left just after a rising edge
  task automatic send_sample(logic [31:0] s);
    bit hit;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    do @(posedge clk); while (!in_tready);
    gate_step(s, hit);
    hit_queue.insert(hit_queue.size(), hit);
    items_sent++;
  endtask

  // wait until every expected result has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (hit_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] addr, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_addr  <= addr;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (addr)
      CFG_HIGH_Q: q_high      = value;
      CFG_LOW_Q:  q_low       = value;
      CFG_REFR:   refr_frames = value;
      CFG_WARM:   warm_frames = value;
      default: ;
    endcase
  endtask

  task automatic apply_settings(int hq, int lq, int rf, int wf);
    drain_results();
    write_reg(CFG_HIGH_Q, hq[15:0]);
    write_reg(CFG_LOW_Q,  lq[15:0]);
    write_reg(CFG_REFR,   rf[15:0]);
    write_reg(CFG_WARM,   wf[15:0]);
    @(posedge clk);
  endtask

  // novelty-like sample: quiet floor, onset spike, negative dip or arbitrary value
  function automatic logic [31:0] onset_sample(int kind);
    case (kind)
      0: onset_sample = $urandom_range(32'h0003_0000) - 32'h0001_8000;
      1: onset_sample = 32'h0010_0000 + $urandom_range(32'h00F0_0000);
      2: onset_sample = -(32'h0004_0000 + $urandom_range(32'h0004_0000));
      default: onset_sample = $urandom;
    endcase
  endfunction

  // extremes of the sample, seeding with ties, and a clean onset at defaults
  task automatic test_directed();
    logic [31:0] pattern[$];
    pattern = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 32'h7FFF_FFFF,
                32'h8000_0000, 32'h0000_0000, 32'h0002_0000, 32'h0050_0000,
                32'h0000_0001, 32'hFFF0_0000, 32'h0060_0000, 32'h8000_0000,
                32'h0000_8000, 32'h0000_8000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h8000_0001, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0000};
    foreach (pattern[i]) send_sample(pattern[i]);
    drain_results();
  endtask

  // mostly onset bursts with random content, some plain noise
  task automatic test_onset_bursts(int n);
    int sent;
    int lead;
    int len;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(99) < 80) begin
        lead = $urandom_range(6, 1);
        for (int i = 0; i < lead; i++) send_sample(onset_sample(0));
        len = $urandom_range(2, 1);
        for (int i = 0; i < len; i++) send_sample(onset_sample(1));
        send_sample(onset_sample($urandom_range(1) ? 2 : 0));
        sent += lead + len + 1;
      end else begin
        send_sample(onset_sample(3));
        sent++;
      end
    end
  endtask

  // one run of phases under the given flow control
  task automatic test_settings_sweep(int idle, int stall, int n);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    apply_settings(58982, 32768, 4, 5);
    test_onset_bursts(n);
    apply_settings(65535, 0, 0, 0);
    test_onset_bursts(n);
    apply_settings(0, 65535, 65535, 65535);
    test_onset_bursts(n / 2);
    apply_settings(50000, 20000, 2, 10);
    test_onset_bursts(n);
    apply_settings($urandom_range(65535), $urandom_range(65535),
                   $urandom_range(8), $urandom_range(20));
    test_onset_bursts(n / 2);
  endtask

  // generous fixed limit for the slowest item paths
  initial begin
    #200_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    q_high = 58982;
    q_low = 32768;
    refr_frames = 4;
    warm_frames = 5;
    gate_armed = 1'b0;
    est_ready = 1'b0;
    refr_left = 0;
    seen_cnt = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_settings_sweep(0, 0, 85);
    test_settings_sweep(77, 0, 85);
    test_settings_sweep(0, 77, 85);
    test_settings_sweep(33, 33, 85);
    drain_results();
    repeat (100) @(posedge clk);
    $display("covered %0d samples, %0d hits, four flow-control phases", items_sent,
             hits_seen);
    $display("register sweep included quantile, refractory and warmup extremes");
    if (errors == 0 && hit_queue.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
